@@ rtl/dpya_pkg.sv @@
// Shared types, widths and constant tables for the direction angle pipeline.
package dpya_pkg;

   // Working width of the vector datapath (normalized values stay below 2^41,
   // CORDIC gain and the pre-rotation keep them below 2^44).
   localparam int VEC_W      = 45;
   // Width of the magnitude word used to find the normalizing shift.
   localparam int MAG_W      = 41;
   localparam int SHIFT_W    = 6;
   localparam int NORM_STEPS = 6;
   localparam int TURN_W     = 32;
   localparam int DIFF_FRAC  = 8;
   localparam int MAX_STAGES = 24;

   // Inverse CORDIC gain in Q20.
   localparam int              INVK_W    = 20;
   localparam int              INVK_FRAC = 20;
   localparam logic [INVK_W-1:0] INVK_Q20 = 20'd636751;

   localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
   localparam logic [TURN_W-1:0] TURN_HALF    = 32'h8000_0000;

   // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
   localparam logic [TURN_W-1:0] ATAN_TAB [MAX_STAGES] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
   };

   // State of one vector as it moves down the rotation chain.
   typedef struct packed {
      logic signed [VEC_W-1:0]  x;
      logic signed [VEC_W-1:0]  y;
      logic [TURN_W-1:0]        z;
      logic [SHIFT_W-1:0]       shift;
      logic                     axis;
   } cst_type;

endpackage

@@ rtl/dpya_norm.sv @@
// Vector front end: axis detection, normalizing shift and quarter-turn pre-rotation.
module dpya_norm #(
   parameter int TAG_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          valid_i,
   input  logic signed [dpya_pkg::VEC_W-1:0] x_i,
   input  logic signed [dpya_pkg::VEC_W-1:0] y_i,
   input  logic [TAG_W-1:0]              tag_i,
   output logic                          valid_o,
   output dpya_pkg::cst_type             st_o,
   output logic [TAG_W-1:0]              tag_o
);
   import dpya_pkg::*;

   typedef struct packed {
      cst_type          st;
      logic [MAG_W-1:0] m;
   } nrm_type;

   logic [NORM_STEPS+1:0] valid_ff;
   nrm_type               nrm_ff  [NORM_STEPS+1];
   logic [TAG_W-1:0]      tag_ff  [NORM_STEPS+2];
   nrm_type               cls_in;
   cst_type               out_ff;
   cst_type               out_in;

   logic signed [VEC_W-1:0] x_abs;
   logic signed [VEC_W-1:0] y_abs;
   logic signed [VEC_W-1:0] px;
   logic signed [VEC_W-1:0] py;

   // Classify: axis vectors get their exact result here and skip the rotations.
   always_comb begin
      x_abs = x_i[VEC_W-1] ? -x_i : x_i;
      y_abs = y_i[VEC_W-1] ? -y_i : y_i;
      cls_in.st.x     = x_i;
      cls_in.st.y     = y_i;
      cls_in.st.z     = '0;
      cls_in.st.shift = '0;
      cls_in.st.axis  = 1'b0;
      cls_in.m        = x_abs[MAG_W-1:0] | y_abs[MAG_W-1:0];
      priority if (y_i == '0) begin
         cls_in.st.axis = 1'b1;
         cls_in.st.x    = x_abs;
         cls_in.st.y    = '0;
         cls_in.st.z    = x_i[VEC_W-1] ? TURN_HALF : '0;
         cls_in.m       = MAG_W'(1) << (MAG_W - 1);
      end else if (x_i == '0) begin
         cls_in.st.axis = 1'b1;
         cls_in.st.x    = y_abs;
         cls_in.st.y    = '0;
         cls_in.st.z    = y_i[VEC_W-1] ? (TURN_W'(0) - TURN_QUARTER) : TURN_QUARTER;
         cls_in.m       = MAG_W'(1) << (MAG_W - 1);
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NORM_STEPS:0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nrm_ff[0] <= cls_in;
         tag_ff[0] <= tag_i;
      end
   end

   // Binary search for the shift: try 32, 16, ..., 1 while the top bits are clear.
   for (genvar j = 0; j < NORM_STEPS; j++) begin : g_step
      localparam int K = 1 << (NORM_STEPS - 1 - j);
      nrm_type step_in;

      always_comb begin
         step_in = nrm_ff[j];
         if (nrm_ff[j].m[MAG_W-1 -: K] == '0) begin
            step_in.m        = nrm_ff[j].m << K;
            step_in.st.x     = nrm_ff[j].st.x <<< K;
            step_in.st.y     = nrm_ff[j].st.y <<< K;
            step_in.st.shift = nrm_ff[j].st.shift + SHIFT_W'(K);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            nrm_ff[j+1] <= step_in;
            tag_ff[j+1] <= tag_ff[j];
         end
      end
   end

   // Rotate a vector in the left half plane by a quarter turn toward +x.
   always_comb begin
      px     = nrm_ff[NORM_STEPS].st.x;
      py     = nrm_ff[NORM_STEPS].st.y;
      out_in = nrm_ff[NORM_STEPS].st;
      if (!out_in.axis && px[VEC_W-1]) begin
         if (py > 0) begin
            out_in.x = py;
            out_in.y = -px;
            out_in.z = TURN_QUARTER;
         end else begin
            out_in.x = -py;
            out_in.y = px;
            out_in.z = TURN_W'(0) - TURN_QUARTER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff               <= out_in;
         tag_ff[NORM_STEPS+1] <= tag_ff[NORM_STEPS];
      end
   end

   assign valid_o = valid_ff[NORM_STEPS+1];
   assign st_o    = out_ff;
   assign tag_o   = tag_ff[NORM_STEPS+1];

endmodule

@@ rtl/dpya_cell.sv @@
// One CORDIC vectoring micro-rotation cell with its pipeline register.
module dpya_cell #(
   parameter int IDX   = 0,
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              valid_i,
   input  dpya_pkg::cst_type st_i,
   input  logic [TAG_W-1:0]  tag_i,
   output logic              valid_o,
   output dpya_pkg::cst_type st_o,
   output logic [TAG_W-1:0]  tag_o
);
   import dpya_pkg::*;

   logic                    valid_ff;
   cst_type                 st_ff;
   cst_type                 st_in;
   logic [TAG_W-1:0]        tag_ff;
   logic signed [VEC_W-1:0] x_cur;
   logic signed [VEC_W-1:0] y_cur;
   logic signed [VEC_W-1:0] x_sh;
   logic signed [VEC_W-1:0] y_sh;

   // Drive y toward zero; axis vectors pass untouched.
   always_comb begin
      x_cur = st_i.x;
      y_cur = st_i.y;
      x_sh  = x_cur >>> IDX;
      y_sh  = y_cur >>> IDX;
      st_in = st_i;
      if (!st_i.axis) begin
         if (y_cur[VEC_W-1]) begin
            st_in.x = x_cur - y_sh;
            st_in.y = y_cur + x_sh;
            st_in.z = st_i.z - ATAN_TAB[IDX];
         end else begin
            st_in.x = x_cur + y_sh;
            st_in.y = y_cur - x_sh;
            st_in.z = st_i.z + ATAN_TAB[IDX];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff  <= st_in;
         tag_ff <= tag_i;
      end
   end

   assign valid_o = valid_ff;
   assign st_o    = st_ff;
   assign tag_o   = tag_ff;

endmodule

@@ rtl/dpya_vector.sv @@
// atan2 unit: normalizing front end followed by a chain of rotation cells.
module dpya_vector #(
   parameter int STAGES = 16,
   parameter int TAG_W  = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              valid_i,
   input  logic signed [dpya_pkg::VEC_W-1:0] x_i,
   input  logic signed [dpya_pkg::VEC_W-1:0] y_i,
   input  logic [TAG_W-1:0]                  tag_i,
   output logic                              valid_o,
   output dpya_pkg::cst_type                 st_o,
   output logic [TAG_W-1:0]                  tag_o
);
   import dpya_pkg::*;

   logic [STAGES:0]  v_chain;
   cst_type          st_chain  [STAGES+1];
   logic [TAG_W-1:0] tag_chain [STAGES+1];

   dpya_norm #(.TAG_W(TAG_W)) u_norm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (valid_i),
      .x_i     (x_i),
      .y_i     (y_i),
      .tag_i   (tag_i),
      .valid_o (v_chain[0]),
      .st_o    (st_chain[0]),
      .tag_o   (tag_chain[0])
   );

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      dpya_cell #(.IDX(i), .TAG_W(TAG_W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (v_chain[i]),
         .st_i    (st_chain[i]),
         .tag_i   (tag_chain[i]),
         .valid_o (v_chain[i+1]),
         .st_o    (st_chain[i+1]),
         .tag_o   (tag_chain[i+1])
      );
   end

   assign valid_o = v_chain[STAGES];
   assign st_o    = st_chain[STAGES];
   assign tag_o   = tag_chain[STAGES];

endmodule

@@ rtl/dpya_mag.sv @@
// Gain compensation of the CORDIC x output, split multiply and rounding shift.
module dpya_mag #(
   parameter int TAG_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              valid_i,
   input  dpya_pkg::cst_type                 st_i,
   input  logic [TAG_W-1:0]                  tag_i,
   output logic                              valid_o,
   output logic signed [dpya_pkg::VEC_W-1:0] h_o,
   output logic [TAG_W-1:0]                  tag_o
);
   import dpya_pkg::*;

   localparam int SPLIT  = 22;
   localparam int HI_W   = VEC_W - SPLIT;
   localparam int PHI_W  = HI_W + INVK_W;
   localparam int PLO_W  = SPLIT + INVK_W;
   localparam int PROD_W = 64;
   localparam int AMT_W  = 7;

   logic [2:0]              valid_ff;
   logic [PHI_W-1:0]        phi_ff;
   logic [PLO_W-1:0]        plo_ff;
   logic signed [VEC_W-1:0] xa_ff;
   logic signed [VEC_W-1:0] xb_ff;
   logic [SHIFT_W-1:0]      sa_ff;
   logic [SHIFT_W-1:0]      sb_ff;
   logic                    axa_ff;
   logic                    axb_ff;
   logic [TAG_W-1:0]        taga_ff;
   logic [TAG_W-1:0]        tagb_ff;
   logic [TAG_W-1:0]        tagc_ff;
   logic [PROD_W-1:0]       prod_in;
   logic [PROD_W-1:0]       prod_ff;
   logic signed [VEC_W-1:0] h_in;
   logic signed [VEC_W-1:0] h_ff;

   // Sum the partial products and add the rounding half unit for this shift.
   always_comb begin
      prod_in = (PROD_W'(phi_ff) << SPLIT) + PROD_W'(plo_ff)
              + (PROD_W'(1) << (AMT_W'(sa_ff) + AMT_W'(INVK_FRAC - 1)));
   end

   // Axis vectors carry an exact magnitude and bypass the compensation.
   always_comb begin
      if (axb_ff) begin
         h_in = xb_ff;
      end else begin
         h_in = VEC_W'(prod_ff >> (AMT_W'(sb_ff) + AMT_W'(INVK_FRAC)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         phi_ff  <= PHI_W'(st_i.x[VEC_W-1:SPLIT]) * PHI_W'(INVK_Q20);
         plo_ff  <= PLO_W'(st_i.x[SPLIT-1:0]) * PLO_W'(INVK_Q20);
         xa_ff   <= st_i.x;
         sa_ff   <= st_i.shift;
         axa_ff  <= st_i.axis;
         taga_ff <= tag_i;
         prod_ff <= prod_in;
         xb_ff   <= xa_ff;
         sb_ff   <= sa_ff;
         axb_ff  <= axa_ff;
         tagb_ff <= taga_ff;
         h_ff    <= h_in;
         tagc_ff <= tagb_ff;
      end
   end

   assign valid_o = valid_ff[2];
   assign h_o     = h_ff;
   assign tag_o   = tagc_ff;

endmodule

@@ rtl/direction_pitch_yaw_angles.sv @@
// Top level: pitch and yaw toward a destination point, fully pipelined.
//
// Accepts one request per clock while req_tready is high and returns one
// response per request, in order. Each request carries a destination and a
// current position; the response holds pitch = full turn - atan2(dz,
// |(dx, dy)|) and yaw = quarter turn - atan2(dx, dy), both as binary angles
// with 2^ANGLE_BITS units per turn, rounded to nearest. The pipeline has
// one input register, two atan2 units of 8 front-end stages plus one
// rotation cell per CORDIC stage each, three stages of gain compensation
// and the output register. Throughput is set by the rotation cell chain,
// which takes a new vector every cycle while the pipeline advances. A
// two-entry output buffer decouples the sides: req_tready comes from a
// register and drops only when both entries hold responses.
// When dx = dy = 0 the yaw is a quarter turn and the pitch follows the sign
// of dz alone; a result of a full turn reads as zero.
module direction_pitch_yaw_angles #(
   parameter int COORD_BITS    = 20,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // dest_x, dest_y, dest_z, pos_x, pos_y, pos_z (lowest bits first)
   input  logic [((6*COORD_BITS+7)/8)*8-1:0]         req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // pitch_angle, yaw_angle (lowest bits first), zero padded
   output logic [((2*ANGLE_BITS+7)/8)*8-1:0]         rsp_tdata
);
   import dpya_pkg::*;

   localparam int RSP_W  = ((2*ANGLE_BITS+7)/8)*8;
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int EXT_W  = VEC_W - DIFF_W - DIFF_FRAC;
   localparam int MTAG_W = ANGLE_BITS + DIFF_W;

   function automatic logic [ANGLE_BITS-1:0] to_bam(input logic [TURN_W-1:0] turn);
      logic [TURN_W-1:0] r;
      r = turn + (TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS));
      return r[TURN_W-1 -: ANGLE_BITS];
   endfunction

   // Request fields.
   logic [COORD_BITS-1:0] dest_x, dest_y, dest_z, pos_x, pos_y, pos_z;

   assign dest_x = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign dest_y = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign dest_z = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign pos_x  = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign pos_y  = req_tdata[4*COORD_BITS +: COORD_BITS];
   assign pos_z  = req_tdata[5*COORD_BITS +: COORD_BITS];

   logic advance;
   logic skid_ff, skid_in;
   logic in_valid_ff;
   logic [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [VEC_W-1:0] dx_s, dy_s, dz_s;

   // Pipeline moves whenever the output buffer has a free entry.
   assign advance    = !skid_ff;
   assign req_tready = advance;

   // Travel vector, one extra bit so the difference cannot overflow.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff <= {dest_x[COORD_BITS-1], dest_x} - {pos_x[COORD_BITS-1], pos_x};
         dy_ff <= {dest_y[COORD_BITS-1], dest_y} - {pos_y[COORD_BITS-1], pos_y};
         dz_ff <= {dest_z[COORD_BITS-1], dest_z} - {pos_z[COORD_BITS-1], pos_z};
      end
   end

   // Scale to 8 fraction bits and sign extend to the datapath width.
   assign dx_s = {{EXT_W{dx_ff[DIFF_W-1]}}, dx_ff, DIFF_FRAC'(0)};
   assign dy_s = {{EXT_W{dy_ff[DIFF_W-1]}}, dy_ff, DIFF_FRAC'(0)};

   // Yaw: atan2(dx, dy), carrying dz alongside for the pitch.
   logic              yv_valid;
   cst_type           yv_st;
   logic [DIFF_W-1:0] yv_dz;

   dpya_vector #(.STAGES(CORDIC_STAGES), .TAG_W(DIFF_W)) u_yaw (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (in_valid_ff),
      .x_i     (dy_s),
      .y_i     (dx_s),
      .tag_i   (dz_ff),
      .valid_o (yv_valid),
      .st_o    (yv_st),
      .tag_o   (yv_dz)
   );

   logic [ANGLE_BITS-1:0]   yaw_early;
   logic                    mg_valid;
   logic signed [VEC_W-1:0] mg_h;
   logic [MTAG_W-1:0]       mg_tag;
   logic [DIFF_W-1:0]       mg_dz;
   logic [ANGLE_BITS-1:0]   mg_yaw;

   assign yaw_early = to_bam(TURN_QUARTER - yv_st.z);

   // Horizontal distance from the yaw rotation's x output.
   dpya_mag #(.TAG_W(MTAG_W)) u_mag (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (yv_valid),
      .st_i    (yv_st),
      .tag_i   ({yaw_early, yv_dz}),
      .valid_o (mg_valid),
      .h_o     (mg_h),
      .tag_o   (mg_tag)
   );

   assign mg_dz  = mg_tag[DIFF_W-1:0];
   assign mg_yaw = mg_tag[MTAG_W-1:DIFF_W];
   assign dz_s   = {{EXT_W{mg_dz[DIFF_W-1]}}, mg_dz, DIFF_FRAC'(0)};

   // Pitch: atan2(dz, h), carrying the finished yaw.
   logic                  pv_valid;
   cst_type               pv_st;
   logic [ANGLE_BITS-1:0] pv_yaw;
   logic [ANGLE_BITS-1:0] pv_pitch;

   dpya_vector #(.STAGES(CORDIC_STAGES), .TAG_W(ANGLE_BITS)) u_pitch (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (mg_valid),
      .x_i     (mg_h),
      .y_i     (dz_s),
      .tag_i   (mg_yaw),
      .valid_o (pv_valid),
      .st_o    (pv_st),
      .tag_o   (pv_yaw)
   );

   assign pv_pitch = to_bam(TURN_W'(0) - pv_st.z);

   // Output register plus skid entry.
   logic                  out_valid_ff, out_valid_in;
   logic [ANGLE_BITS-1:0] out_pitch_ff, out_pitch_in;
   logic [ANGLE_BITS-1:0] out_yaw_ff, out_yaw_in;
   logic [ANGLE_BITS-1:0] skid_pitch_ff, skid_pitch_in;
   logic [ANGLE_BITS-1:0] skid_yaw_ff, skid_yaw_in;
   logic                  take;
   logic                  push;

   assign take = out_valid_ff && rsp_tready;
   assign push = advance && pv_valid;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_pitch_in  = out_pitch_ff;
      out_yaw_in    = out_yaw_ff;
      skid_in       = skid_ff;
      skid_pitch_in = skid_pitch_ff;
      skid_yaw_in   = skid_yaw_ff;
      priority if (skid_ff) begin
         // Drain the skid entry into the freed output register.
         if (take) begin
            out_valid_in = 1'b1;
            out_pitch_in = skid_pitch_ff;
            out_yaw_in   = skid_yaw_ff;
            skid_in      = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = push;
         out_pitch_in = pv_pitch;
         out_yaw_in   = pv_yaw;
      end else if (push) begin
         // Output held: park the new response.
         skid_in       = 1'b1;
         skid_pitch_in = pv_pitch;
         skid_yaw_in   = pv_yaw;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_ff      <= skid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pitch_ff  <= out_pitch_in;
      out_yaw_ff    <= out_yaw_in;
      skid_pitch_ff <= skid_pitch_in;
      skid_yaw_ff   <= skid_yaw_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_yaw_ff, out_pitch_ff});

   // The skid entry only fills behind a held output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_ff |-> out_valid_ff)
      else $error("skid entry full while output register empty");

   a_push_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp_tready) |=> skid_ff)
      else $error("response pushed into a held output was not parked");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_ff && rsp_tready) |=>
         (!skid_ff && out_valid_ff && out_pitch_ff == $past(skid_pitch_ff)
          && out_yaw_ff == $past(skid_yaw_ff)))
      else $error("skid entry not moved to the output register");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      (skid_ff && !rsp_tready) |=> (skid_ff && $stable(skid_pitch_ff)))
      else $error("parked response lost while output held");

endmodule
